### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge out of reset.
`define SRTF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define SRTF_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

### src/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and codes shared by the SRTF scheduler controller and datapath.
// ----------------------------------------------------------------------------
package srtf_pkg;

	// Command opcodes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_STORED   = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_IDLE     = 2'd2;
	localparam logic [1:0] ST_RAN      = 2'd3;

	// One job table entry
	typedef struct packed {
		logic [7:0] id;
		logic [7:0] remaining;
		logic [7:0] stamp;
	} slot_entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted transaction, reset the scan
		logic scan;    // issue one table read, advance the slot index
		logic commit;  // update state and load the result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;  // index points at the last slot
		logic out_room;   // result register free or being taken
	} dp_stat_t;

endpackage

### src/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: accept, scan all slots, drain the read pipe, commit.
// ----------------------------------------------------------------------------
module srtf_ctrl
	import srtf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_LAST   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = cmd_valid;
				if (cmd_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_LAST;
				end
			end
			// last read result is compared during this cycle
			S_LAST: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = stat.out_room;
				if (stat.out_room) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/srtf_dp.sv
// ----------------------------------------------------------------------------
// srtf_dp
// Job table, slot scan with best-candidate tracking, state update and
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srtf_dp
	import srtf_pkg::*;
#(
	parameter int JOB_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic        opcode,
	input  logic [7:0]  job_id,
	input  logic [7:0]  job_burst,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [7:0]  ran_id,
	output logic        first_run,
	output logic        switched,
	output logic        finished,
	output logic [7:0]  remaining_after,
	output logic [31:0] time_now
);

	localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(JOB_SLOTS - 1);

	// captured transaction
	logic        op_q;
	logic [7:0]  jid_q;
	logic [7:0]  burst_q;

	// slot state
	logic [JOB_SLOTS-1:0] slot_valid_q;
	logic [JOB_SLOTS-1:0] slot_started_q;
	slot_entry_t          slot_mem [JOB_SLOTS];
	logic [7:0]           stamp_cnt_q;
	logic [31:0]          time_q;
	logic [IW-1:0]        prev_id_q;
	logic                 prev_valid_q;

	// scan
	logic [IW-1:0] idx_q;
	logic          rd_valid_s1;
	logic          slot_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	slot_entry_t   rd_data_s1;

	// best candidate
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [7:0]    best_rem_q;
	logic [7:0]    best_age_q;
	slot_entry_t   best_q;

	// result register
	logic        res_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  ran_id_q;
	logic        first_run_q;
	logic        switched_q;
	logic        finished_q;
	logic [7:0]  remaining_q;
	logic [31:0] time_now_q;

	logic [7:0]  age;
	logic        take;
	logic        tick;
	logic [7:0]  rem_dec;
	logic [7:0]  burst_fix;
	logic        started_best;
	logic        sw_best;
	logic        mem_we;
	slot_entry_t mem_wdata;
	logic        commit_tick_hit;
	logic        commit_arrive_hit;

	assign tick = (op_q == OP_TICK);
	assign age  = stamp_cnt_q - rd_data_s1.stamp;

	// strict compare keeps the lower slot on a full tie
	always_comb begin
		if (tick) begin
			take = slot_vld_s1 && (!found_q || (rd_data_s1.remaining < best_rem_q) ||
				((rd_data_s1.remaining == best_rem_q) && (age > best_age_q)));
		end else begin
			take = !slot_vld_s1 && !found_q;
		end
	end

	assign rem_dec      = (best_rem_q != 8'd0) ? best_rem_q - 8'd1 : 8'd0;
	assign burst_fix    = (burst_q == 8'd0) ? 8'd1 : burst_q;
	assign started_best = slot_started_q[best_idx_q];
	assign sw_best      = started_best && prev_valid_q && (prev_id_q != best_idx_q);

	assign commit_tick_hit   = cmd.commit && tick && found_q;
	assign commit_arrive_hit = cmd.commit && !tick && found_q;

	assign mem_we = commit_tick_hit || commit_arrive_hit;
	always_comb begin
		if (tick) begin
			mem_wdata = '{id: best_q.id, remaining: rem_dec, stamp: best_q.stamp};
		end else begin
			mem_wdata = '{id: jid_q, remaining: burst_fix, stamp: stamp_cnt_q};
		end
	end

	assign stat.scan_last = (idx_q == LAST_IDX);
	assign stat.out_room  = !res_valid_q || !res_stall;

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[best_idx_q] <= mem_wdata;
		end
		if (cmd.scan) begin
			rd_data_s1 <= slot_mem[idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			jid_q   <= job_id;
			burst_q <= job_burst;
		end
		if (cmd.scan) begin
			rd_idx_s1   <= idx_q;
			slot_vld_s1 <= slot_valid_q[idx_q];
		end
		if (rd_valid_s1 && take) begin
			best_idx_q <= rd_idx_s1;
			best_rem_q <= rd_data_s1.remaining;
			best_age_q <= age;
			best_q     <= rd_data_s1;
		end
		if (cmd.commit) begin
			if (tick) begin
				status_q    <= found_q ? ST_RAN : ST_IDLE;
				ran_id_q    <= found_q ? best_q.id : 8'd0;
				first_run_q <= found_q && !started_best;
				switched_q  <= found_q && sw_best;
				finished_q  <= found_q && (rem_dec == 8'd0);
				remaining_q <= found_q ? rem_dec : 8'd0;
				time_now_q  <= time_q + 32'd1;
			end else begin
				status_q    <= found_q ? ST_STORED : ST_REJECTED;
				ran_id_q    <= jid_q;
				first_run_q <= 1'b0;
				switched_q  <= 1'b0;
				finished_q  <= 1'b0;
				remaining_q <= found_q ? burst_fix : 8'd0;
				time_now_q  <= time_q;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q   <= '0;
			slot_started_q <= '0;
			stamp_cnt_q    <= 8'd0;
			time_q         <= 32'd0;
			prev_id_q      <= '0;
			prev_valid_q   <= 1'b0;
			idx_q          <= '0;
			rd_valid_s1    <= 1'b0;
			found_q        <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_valid_s1 && take) begin
				found_q <= 1'b1;
			end
			if (cmd.commit && tick) begin
				time_q <= time_q + 32'd1;
			end
			if (commit_tick_hit) begin
				slot_started_q[best_idx_q] <= 1'b1;
				if (rem_dec == 8'd0) begin
					slot_valid_q[best_idx_q] <= 1'b0;
				end
				prev_id_q    <= best_idx_q;
				prev_valid_q <= 1'b1;
			end
			if (commit_arrive_hit) begin
				slot_valid_q[best_idx_q]   <= 1'b1;
				slot_started_q[best_idx_q] <= 1'b0;
				stamp_cnt_q                <= stamp_cnt_q + 8'd1;
			end
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid       = res_valid_q;
	assign status          = status_q;
	assign ran_id          = ran_id_q;
	assign first_run       = first_run_q;
	assign switched        = switched_q;
	assign finished        = finished_q;
	assign remaining_after = remaining_q;
	assign time_now        = time_now_q;

	`SRTF_IMPLIES(a_commit_room, clk, arst_n, cmd.commit, !res_valid_q || !res_stall, "commit with full result register")
	`SRTF_IMPLIES(a_run_slot_valid, clk, arst_n, commit_tick_hit, slot_valid_q[best_idx_q], "chosen job slot not valid")
	`SRTF_IMPLIES(a_run_rem_nonzero, clk, arst_n, commit_tick_hit, best_rem_q != 8'd0, "chosen job has no time left")
	`SRTF_IMPLIES(a_store_slot_free, clk, arst_n, commit_arrive_hit, !slot_valid_q[best_idx_q], "arrival into occupied slot")

endmodule

### src/shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive SRTF scheduler: arrivals fill a job table, ticks run the job
// with least remaining time (ties to the earliest arrival).
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   command | cmd_valid | cmd_stall | opcode, job_id, job_burst
//   result  | res_valid | res_stall | status, ran_id, first_run, switched,
//           |           |           | finished, remaining_after, time_now
//
// One transaction at a time; each command is paced by the one-slot-per-cycle
// table scan through a single read port.
// No clearing pass after reset; the table is usable on the first cycle.
// A stalled result holds in the output register; the next command is taken
// meanwhile and waits at commit until the register frees.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler
	import srtf_pkg::*;
#(
	parameter int JOB_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        opcode,
	input  logic [7:0]  job_id,
	input  logic [7:0]  job_burst,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [7:0]  ran_id,
	output logic        first_run,
	output logic        switched,
	output logic        finished,
	output logic [7:0]  remaining_after,
	output logic [31:0] time_now
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	srtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	srtf_dp #(
		.JOB_SLOTS (JOB_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.job_id          (job_id),
		.job_burst       (job_burst),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.status          (status),
		.ran_id          (ran_id),
		.first_run       (first_run),
		.switched        (switched),
		.finished        (finished),
		.remaining_after (remaining_after),
		.time_now        (time_now)
	);

endmodule
